[hw/rtl/pats_pkg.sv]
// Shared types and constants for the priority aging task scheduler.
`default_nettype none

package pats_pkg;

   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_REMOVE = 3'd1,
      OP_SETPRI = 3'd2,
      OP_SLEEP  = 3'd3,
      OP_TICK   = 3'd4,
      OP_PICK   = 3'd5
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_AGE  = 4'b0100,
      ST_POST = 4'b1000
   } state_type;

   localparam logic signed [6:0] PRIO_MAX    = 7'sd20;
   localparam logic signed [6:0] PRIO_MIN    = -7'sd20;
   localparam logic signed [8:0] LEVEL_FLOOR = -9'sd128;
   localparam logic [2:0]        AGING_STEP_RESET = 3'd1;

endpackage : pats_pkg

`default_nettype wire

[hw/rtl/pats_if.sv]
// Valid/ready channel interfaces for scheduler commands and results.
`default_nettype none

interface pats_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        op;
   logic [3:0]        slot;
   logic signed [6:0] priority_req;
   logic [15:0]       sleep_duration;

   modport source (output valid, op, slot, priority_req, sleep_duration, input ready);
   modport sink   (input valid, op, slot, priority_req, sleep_duration, output ready);
endinterface : pats_req_if

interface pats_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] chosen_slot;
   logic       chosen_valid;
   logic       error;

   modport source (output valid, chosen_slot, chosen_valid, error, input ready);
   modport sink   (input valid, chosen_slot, chosen_valid, error, output ready);
endinterface : pats_rsp_if

`default_nettype wire

[hw/rtl/priority_aging_task_scheduler_core.sv]
// Top level: task slot table, pick sequencer and shared compare/age unit.
//
// Usage: commands arrive as words on req_ch (add, remove, set priority,
// sleep, tick, pick); every command yields exactly one word on rsp_ch
// carrying chosen_slot, chosen_valid and error. csr_wr_en/csr_wr_data
// write aging_step; write it only while no command is in flight.
// Sequencing: add, remove, set priority, sleep and tick update the table
// in the accept cycle and pass their result through the POST state to the
// output register. A pick walks the slot table twice through one
// compare/subtract unit, one slot per cycle: a wake-and-select pass and an
// age pass (the age pass is skipped when nothing is ready), then POST.
// Flow: one command at a time; req_ch.ready rises as the result is
// loaded into the output register. The next command is taken while a
// result still waits in the output register.
// Reset (synchronous, active high) clears all ready and sleep flags, the
// tick counter and the output valid flag, and sets aging_step to 1.
// Receiver stall: the result holds in the output register; at most one
// further command is accepted and its result waits until the word leaves.
`default_nettype none

module priority_aging_task_scheduler_core #(
   parameter int TASK_SLOTS = 16
) (
   input  wire        clock,
   input  wire        reset,
   pats_req_if.sink   req_ch,
   pats_rsp_if.source rsp_ch,
   input  wire        csr_wr_en,
   input  wire  [2:0] csr_wr_data
);
   import pats_pkg::*;

   localparam int               IDX_W     = $clog2(TASK_SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TASK_SLOTS - 1);
   localparam logic [6:0]       SLOTS_W7  = 7'(TASK_SLOTS);

   // slot table
   logic [TASK_SLOTS-1:0] ready_ff;
   logic [TASK_SLOTS-1:0] asleep_ff;
   logic [31:0]           wake_ff    [TASK_SLOTS];
   logic signed [5:0]     static_ff  [TASK_SLOTS];
   logic signed [7:0]     dynamic_ff [TASK_SLOTS];
   logic [31:0]           time_ff;
   logic [2:0]            aging_step_ff;

   // sequencer
   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              best_valid_ff, best_valid_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic signed [7:0] best_level_ff, best_level_in;

   // pending result and output register
   logic       res_valid_ff, res_error_ff;
   logic [3:0] res_slot_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [3:0] rsp_slot_ff;
   logic       rsp_chosen_ff, rsp_error_ff;

   logic              req_fire;
   op_type            req_op;
   logic [IDX_W-1:0]  slot_idx;
   logic              slot_ok, prio_ok;
   logic              out_free;

   logic              wake_hit, scan_ready;
   logic signed [7:0] dyn_rd;
   logic signed [8:0] age_diff;
   logic signed [7:0] age_level;
   logic signed [7:0] static_ext;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign req_op       = op_type'(req_ch.op);
   assign slot_idx     = IDX_W'(req_ch.slot);
   assign slot_ok      = {3'b000, req_ch.slot} < SLOTS_W7;
   assign prio_ok      = (req_ch.priority_req >= PRIO_MIN) &&
                         (req_ch.priority_req <= PRIO_MAX);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // shared unit: wake compare, level compare, saturating age
   assign dyn_rd     = dynamic_ff[idx_ff];
   assign wake_hit   = asleep_ff[idx_ff] && (wake_ff[idx_ff] <= time_ff);
   assign scan_ready = ready_ff[idx_ff] || wake_hit;
   assign age_diff   = $signed({dyn_rd[7], dyn_rd}) - $signed({6'b000000, aging_step_ff});
   assign age_level  = (age_diff < LEVEL_FLOOR) ? LEVEL_FLOOR[7:0] : age_diff[7:0];
   assign static_ext = {{2{static_ff[idx_ff][5]}}, static_ff[idx_ff]};

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      best_valid_in = best_valid_ff;
      best_idx_in   = best_idx_ff;
      best_level_in = best_level_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               idx_in        = '0;
               best_valid_in = 1'b0;
               state_in      = (req_op == OP_PICK) ? ST_SCAN : ST_POST;
            end
         end
         ST_SCAN: begin
            if (scan_ready && (!best_valid_ff || dyn_rd < best_level_ff)) begin
               best_valid_in = 1'b1;
               best_idx_in   = idx_ff;
               best_level_in = dyn_rd;
            end
            if (idx_ff == LAST_IDX) begin
               idx_in = '0;
               // skip aging when no slot is ready
               state_in = (best_valid_in) ? ST_AGE : ST_POST;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_AGE: begin
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = ST_POST;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_POST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         best_valid_ff <= best_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff   <= best_idx_in;
      best_level_ff <= best_level_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         aging_step_ff <= AGING_STEP_RESET;
      end else if (csr_wr_en) begin
         aging_step_ff <= csr_wr_data;
      end
   end

   // flags and tick counter
   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff  <= '0;
         asleep_ff <= '0;
         time_ff   <= '0;
      end else if (req_fire) begin
         unique case (req_op)
            OP_ADD: begin
               if (prio_ok && slot_ok) begin
                  ready_ff[slot_idx]  <= 1'b1;
                  asleep_ff[slot_idx] <= 1'b0;
               end
            end
            OP_REMOVE: begin
               if (slot_ok) begin
                  ready_ff[slot_idx]  <= 1'b0;
                  asleep_ff[slot_idx] <= 1'b0;
               end
            end
            OP_SLEEP: begin
               if (slot_ok && ready_ff[slot_idx]) begin
                  ready_ff[slot_idx]  <= 1'b0;
                  asleep_ff[slot_idx] <= 1'b1;
               end
            end
            OP_TICK: time_ff <= time_ff + 32'd1;
            default: ;
         endcase
      end else if (state_ff == ST_SCAN && wake_hit) begin
         // wake the sleeper
         ready_ff[idx_ff]  <= 1'b1;
         asleep_ff[idx_ff] <= 1'b0;
      end
   end

   // slot payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         if ((req_op == OP_ADD || req_op == OP_SETPRI) && prio_ok && slot_ok) begin
            static_ff[slot_idx]  <= req_ch.priority_req[5:0];
            dynamic_ff[slot_idx] <= {req_ch.priority_req[6], req_ch.priority_req};
         end
         if (req_op == OP_SLEEP && slot_ok && ready_ff[slot_idx]) begin
            wake_ff[slot_idx] <= time_ff + {16'h0000, req_ch.sleep_duration};
         end
      end else if (state_ff == ST_AGE) begin
         if (idx_ff == best_idx_ff) begin
            dynamic_ff[idx_ff] <= static_ext;
         end else if (ready_ff[idx_ff]) begin
            dynamic_ff[idx_ff] <= age_level;
         end
      end
   end

   // pending result
   always_ff @(posedge clock) begin
      if (req_fire) begin
         res_slot_ff  <= 4'h0;
         res_valid_ff <= 1'b0;
         res_error_ff <= (req_op == OP_ADD || req_op == OP_SETPRI) && !prio_ok;
      end else if (state_ff == ST_AGE && idx_ff == LAST_IDX) begin
         res_slot_ff  <= 4'(best_idx_ff);
         res_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_POST && out_free) begin
         rsp_slot_ff   <= res_slot_ff;
         rsp_chosen_ff <= res_valid_ff;
         rsp_error_ff  <= res_error_ff;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.chosen_slot  = rsp_slot_ff;
   assign rsp_ch.chosen_valid = rsp_chosen_ff;
   assign rsp_ch.error        = rsp_error_ff;

`ifndef ASSERT_OFF
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_pick_scans: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_op == OP_PICK) |=> (state_ff == ST_SCAN && idx_ff == '0))
      else $error("pick did not start the table scan");

   a_age_has_best: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_AGE) |-> (best_valid_ff && ready_ff[best_idx_ff]))
      else $error("age pass without a ready chosen slot");

   a_rsp_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_chosen_ff && rsp_error_ff))
      else $error("result both chosen and in error");

   a_post_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POST && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result not moved to output register");
`endif

endmodule : priority_aging_task_scheduler_core

`default_nettype wire
